>>> hw/rtl/mnpt_pkg.sv
// Shared types and constants for the MIDI note priority tracker.
// Used by mnpt_ctrl, mnpt_dp and the top level; no dependencies.
package mnpt_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int COUNT_W = 8;
    localparam int TYPE_W  = 4;
    localparam int CH_W    = 4;
    localparam int OUT_W   = 24;

    // Result packing, lowest bit first.
    localparam int OFS_TOP    = 0;
    localparam int OFS_HELD   = 7;
    localparam int OFS_RETRIG = 15;
    localparam int OFS_REL    = 16;
    localparam int OFS_PITCH  = 17;
    localparam int PAD_W      = OUT_W - OFS_PITCH - 1;

    // Message type codes (upper nibble of a status byte).
    localparam logic [TYPE_W-1:0] MSG_NONE     = 4'd0;
    localparam logic [TYPE_W-1:0] MSG_NOTE_OFF = 4'd8;
    localparam logic [TYPE_W-1:0] MSG_NOTE_ON  = 4'd9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // input transaction this cycle
        logic exec;    // apply the completed note message
        logic scan;    // one step of the downward held-note search
        logic post;    // load the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic msg_done;    // the offered byte completes a note message
        logic need_scan;   // top note was released, search required
        logic scan_found;  // search has reached its answer
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

>>> hw/rtl/mnpt_ctrl.sv
// Sequencing state machine for the MIDI note priority tracker.
// Depends on mnpt_pkg for the command and status structs.
module mnpt_ctrl import mnpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_POST = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Bytes are taken only while no message is being applied.
    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_cmd.accept = o_s_tready & i_s_tvalid;
    assign o_cmd.exec   = (r_state == ST_EXEC);
    assign o_cmd.scan   = (r_state == ST_SCAN);
    assign o_cmd.post   = (r_state == ST_POST) & i_sts.out_free;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.msg_done) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.need_scan ? ST_SCAN : ST_POST;
            end
            ST_SCAN: begin
                if (i_sts.scan_found) n_state = ST_POST;
            end
            ST_POST: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/mnpt_dp.sv
// Datapath of the MIDI note priority tracker: byte parser, velocity
// memory with valid bits, held-note search and output register. Uses mnpt_pkg.
module mnpt_dp import mnpt_pkg::*; #(
    parameter int NOTE_COUNT = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CH_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]  i_s_tdata,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [OUT_W-1:0]   o_m_tdata,
    input  t_cmd               i_cmd,
    output t_sts               o_sts
);

    localparam int ADDR_W = $clog2(NOTE_COUNT);

    // Configuration and parser state.
    logic [CH_W-1:0]   r_listen_ch;
    logic [TYPE_W-1:0] r_type;
    logic [NOTE_W-1:0] r_first;
    logic              r_first_vld;

    // Completed message.
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic              r_is_on;

    // Note store.
    logic [VEL_W-1:0]      r_vel_mem [NOTE_COUNT];
    logic [NOTE_COUNT-1:0] r_valid;
    logic [ADDR_W-1:0]     rd_addr;
    logic [VEL_W-1:0]      r_rd_vel;
    logic                  r_rd_vld;
    logic                  rd_held;

    // Tracker state and result flags.
    logic [COUNT_W-1:0] r_held;
    logic [NOTE_W-1:0]  r_highest;
    logic               r_retrig;
    logic               r_rel;
    logic               r_pitch;

    // Search pipeline: address issued, and address whose data is back.
    logic [ADDR_W-1:0] r_scan_addr;
    logic [ADDR_W-1:0] r_chk_addr;
    logic              r_chk_vld;

    // Output register.
    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;

    logic               is_note_type;
    logic               in_range;
    logic [ADDR_W-1:0]  note_addr;
    logic               do_store;
    logic               do_clear;
    logic [COUNT_W-1:0] held_dec;

    assign is_note_type = (r_type == MSG_NOTE_ON) || (r_type == MSG_NOTE_OFF);
    assign in_range     = {1'b0, r_note} < COUNT_W'(NOTE_COUNT);
    assign note_addr    = r_note[ADDR_W-1:0];
    assign rd_held      = r_rd_vld && (r_rd_vel != '0);
    assign held_dec     = r_held - COUNT_W'(1);

    // Decisions taken while applying a completed message.
    assign do_store = i_cmd.exec && in_range && r_is_on && (r_vel != '0) && !rd_held;
    assign do_clear = i_cmd.exec && in_range && !r_is_on && rd_held;

    // Status toward the controller.
    assign o_sts.msg_done   = !i_s_tdata[BYTE_W-1] && is_note_type && r_first_vld;
    assign o_sts.need_scan  = do_clear && (held_dec != '0) && (r_note == r_highest);
    assign o_sts.scan_found = r_chk_vld && (rd_held || (r_chk_addr == '0));
    assign o_sts.out_free   = !r_out_vld || i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    // Listen channel register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_ch <= '0;
        end else if (i_cfg_valid) begin
            r_listen_ch <= i_cfg_data;
        end
    end

    // Byte parser: status bytes latch the type, data bytes build the message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type      <= MSG_NONE;
            r_first_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_s_tdata[BYTE_W-1]) begin
                if (i_s_tdata[CH_W-1:0] == r_listen_ch) begin
                    r_type <= i_s_tdata[BYTE_W-1:BYTE_W-TYPE_W];
                end
            end else if (!is_note_type) begin
                r_type <= MSG_NONE;
            end else if (!r_first_vld) begin
                r_first_vld <= 1'b1;
            end else begin
                r_type      <= MSG_NONE;
                r_first_vld <= 1'b0;
            end
        end
    end

    // Message payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_s_tdata[BYTE_W-1] && is_note_type) begin
            if (!r_first_vld) begin
                r_first <= i_s_tdata[NOTE_W-1:0];
            end else begin
                r_note  <= r_first;
                r_vel   <= i_s_tdata[VEL_W-1:0];
                r_is_on <= (r_type == MSG_NOTE_ON);
            end
        end
    end

    // Velocity memory: one write port, one registered read port.
    assign rd_addr = i_cmd.scan ? r_scan_addr : r_first[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_vel_mem[note_addr] <= r_vel;
        end
        r_rd_vel <= r_vel_mem[rd_addr];
    end

    // Valid bits; an entry that is not valid reads as silent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (do_store) begin
                r_valid[note_addr] <= 1'b1;
            end else if (do_clear) begin
                r_valid[note_addr] <= 1'b0;
            end
            r_rd_vld <= r_valid[rd_addr];
        end
    end

    // Held count, top note and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_highest <= '0;
        end else if (i_cmd.exec) begin
            if (do_store) begin
                r_held <= r_held + COUNT_W'(1);
                if (r_note >= r_highest) begin
                    r_highest <= r_note;
                end
            end else if (do_clear) begin
                r_held <= held_dec;
                if (held_dec == '0) begin
                    r_highest <= '0;
                end
            end
        end else if (i_cmd.scan && o_sts.scan_found) begin
            r_highest <= NOTE_W'(r_chk_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_retrig <= do_store && (r_held == '0);
            r_rel    <= do_clear && (held_dec == '0);
            r_pitch  <= do_store || o_sts.need_scan;
        end
    end

    // Downward search, one memory read issued per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.exec) begin
            r_chk_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_chk_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_scan_addr <= (note_addr == '0) ? '0 : note_addr - ADDR_W'(1);
        end else if (i_cmd.scan) begin
            r_scan_addr <= (r_scan_addr == '0) ? '0 : r_scan_addr - ADDR_W'(1);
            r_chk_addr  <= r_scan_addr;
        end
    end

    // Output register: holds one result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_data <= {{PAD_W{1'b0}}, r_pitch, r_rel, r_retrig, r_held, r_highest};
        end
    end

endmodule

>>> hw/rtl/midi_note_priority_tracker.sv
// Top level of the MIDI note tracker with highest-note priority.
// Instantiates mnpt_ctrl and mnpt_dp; uses mnpt_pkg.
//
// Channel   Direction  Handshake                     Payload
// s (in)    sink       i_s_tvalid / o_s_tready       i_s_tdata: midi_byte
// m (out)   source     o_m_tvalid / i_m_tready       o_m_tdata: result fields
// cfg       sink       i_cfg_valid / o_cfg_ready     i_cfg_data: listen_channel
//
// A status byte or a first data byte is only accepted. A completing data byte
// is accepted, applied and loaded into the output register; when the top note
// is released, the velocity memory is first searched downward, one read per
// cycle, until the next held note is found, which becomes the new top note.
// Synchronous active-low reset clears the valid bits at once; no clearing pass.
// A result held in the output register does not block input bytes; only a new
// result waits for the output register to drain.
module midi_note_priority_tracker import mnpt_pkg::*; #(
    parameter int NOTE_COUNT = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CH_W-1:0]   i_cfg_data,   // listen_channel[3:0]
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,    // midi_byte[7:0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // top_note[6:0], held_count[14:7], retrigger[15], release_res[16],
    // pitch_update[17], zero[23:18]
    output logic [OUT_W-1:0]  o_m_tdata
);

    t_cmd cmd;
    t_sts sts;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    mnpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mnpt_dp #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

`ifndef SYNTH
    // A completed note message is applied in the following cycle.
    a_exec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && sts.msg_done) |=> cmd.exec)
        else $error("completed message was not applied");

    // No byte is taken while the held-note search runs.
    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan |-> !o_s_tready)
        else $error("input accepted during search");

    // Releasing the last note leaves nothing held and no top note.
    a_release_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OFS_REL])
        |-> (o_m_tdata[OFS_RETRIG-1:OFS_HELD] == '0 && o_m_tdata[OFS_HELD-1:OFS_TOP] == '0))
        else $error("release reported with notes still held");

    // A press from silence leaves exactly one note held.
    a_retrig_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OFS_RETRIG])
        |-> (o_m_tdata[OFS_RETRIG-1:OFS_HELD] == COUNT_W'(1)))
        else $error("retrigger with held count other than one");
`endif

endmodule
